>>> hw/rtl/avthc_pkg.sv
package avthc_pkg;

   localparam int unsigned VOLT_W   = 10;
   localparam int unsigned MARGIN_W = 8;
   localparam int unsigned STAB_W   = 16;
   localparam int unsigned WAIT_W   = 8;
   localparam int unsigned PIERCE_W = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned THR_W    = VOLT_W + 2;

   localparam logic [VOLT_W-1:0] KERF_RISE = VOLT_W'(1);

   localparam logic [CSR_IDX_W-1:0] REG_SET_POINT       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ON_MARGIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_MARGIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STABILIZE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KERF_WAIT       = 3'd4;

   localparam logic [VOLT_W-1:0]   SET_POINT_RST       = 10'd0;
   localparam logic [MARGIN_W-1:0] ON_MARGIN_RST       = 8'd4;
   localparam logic [MARGIN_W-1:0] OFF_MARGIN_RST      = 8'd1;
   localparam logic [STAB_W-1:0]   STABILIZE_LIMIT_RST = 16'd500;
   localparam logic [WAIT_W-1:0]   KERF_WAIT_RST       = 8'd7;

   typedef enum logic [1:0] {
      ST_GOOD = 2'd0,
      ST_UP   = 2'd1,
      ST_DOWN = 2'd2,
      ST_KERF = 2'd3
   } status_type;

   typedef struct packed {
      logic                torch_on;
      logic                arc_good;
      logic [VOLT_W-1:0]   arc_voltage;
   } req_type;

   typedef struct packed {
      logic                drive_up;
      logic                drive_down;
      logic [1:0]          torch_status;
      logic                control_active;
      logic                kerf_active;
      logic                cutting;
      logic [PIERCE_W-1:0] pierces;
   } rsp_type;

   typedef struct packed {
      logic [VOLT_W-1:0]   set_point;
      logic [MARGIN_W-1:0] on_margin;
      logic [MARGIN_W-1:0] off_margin;
      logic [STAB_W-1:0]   stabilize_limit;
      logic [WAIT_W-1:0]   kerf_wait;
   } cfg_type;

endpackage

>>> hw/rtl/avthc_if.sv
interface avthc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            torch_on;
   logic                            arc_good;
   logic [avthc_pkg::VOLT_W-1:0]    arc_voltage;

   modport source (output valid, torch_on, arc_good, arc_voltage, input ready);
   modport sink   (input valid, torch_on, arc_good, arc_voltage, output ready);
endinterface

interface avthc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            drive_up;
   logic                            drive_down;
   logic [1:0]                      torch_status;
   logic                            control_active;
   logic                            kerf_active;
   logic                            cutting;
   logic [avthc_pkg::PIERCE_W-1:0]  pierces;

   modport source (output valid, drive_up, drive_down, torch_status, control_active,
                   kerf_active, cutting, pierces, input ready);
   modport sink   (input valid, drive_up, drive_down, torch_status, control_active,
                   kerf_active, cutting, pierces, output ready);
endinterface

>>> hw/rtl/avthc_core.sv
module avthc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  avthc_pkg::req_type  item,
   input  avthc_pkg::cfg_type  cfg,
   output avthc_pkg::rsp_type  result
);

   typedef struct packed {
      logic                               in_cut;
      logic                               prev_arc_good;
      logic                               moving_up;
      logic                               moving_down;
      avthc_pkg::status_type              status_code;
      logic                               regulating;
      logic                               kerf_seen;
      logic [avthc_pkg::VOLT_W-1:0]       kerf_level;
      logic [avthc_pkg::WAIT_W-1:0]       down_count;
      logic [avthc_pkg::STAB_W-1:0]       stabilize_count;
      logic [avthc_pkg::PIERCE_W-1:0]     pierce_total;
   } state_type;

   state_type st_ff;
   state_type st_in;

   always_comb begin
      logic signed [avthc_pkg::THR_W-1:0] v_s;
      logic signed [avthc_pkg::THR_W-1:0] sp_s;
      logic signed [avthc_pkg::THR_W-1:0] on_s;
      logic signed [avthc_pkg::THR_W-1:0] off_s;
      logic [avthc_pkg::VOLT_W:0]         rise_lim;
      st_in    = st_ff;
      v_s      = signed'({2'b00, item.arc_voltage});
      sp_s     = signed'({2'b00, cfg.set_point});
      on_s     = signed'({4'b0000, cfg.on_margin});
      off_s    = signed'({4'b0000, cfg.off_margin});
      rise_lim = {1'b0, st_ff.kerf_level} + {1'b0, avthc_pkg::KERF_RISE};

      if (item.arc_good && !st_ff.prev_arc_good && st_ff.pierce_total != '1) begin
         st_in.pierce_total = st_ff.pierce_total + 1'b1;
      end
      st_in.prev_arc_good = item.arc_good;

      if (!item.torch_on) begin
         st_in.in_cut      = 1'b0;
         st_in.moving_up   = 1'b0;
         st_in.moving_down = 1'b0;
         st_in.status_code = avthc_pkg::ST_GOOD;
         st_in.regulating  = 1'b0;
         st_in.kerf_seen   = 1'b0;
      end else begin
         if (!st_ff.in_cut) begin
            st_in.in_cut          = 1'b1;
            st_in.stabilize_count = '0;
         end else begin
            if (st_ff.stabilize_count != '1) begin
               st_in.stabilize_count = st_ff.stabilize_count + 1'b1;
            end
            if (st_ff.down_count != '1) begin
               st_in.down_count = st_ff.down_count + 1'b1;
            end
         end

         if (!item.arc_good) begin
            st_in.regulating = 1'b0;
            st_in.kerf_seen  = 1'b0;
         end else if (!st_ff.regulating) begin
            if (st_ff.kerf_seen) begin
               if (st_ff.kerf_level >= item.arc_voltage) begin
                  st_in.kerf_seen  = 1'b0;
                  st_in.regulating = 1'b1;
               end
            end else if (st_in.stabilize_count > cfg.stabilize_limit) begin
               st_in.regulating = 1'b1;
            end
         end else if (st_ff.moving_up) begin
            if (v_s >= sp_s - off_s) begin
               st_in.moving_up   = 1'b0;
               st_in.moving_down = 1'b0;
               st_in.status_code = avthc_pkg::ST_GOOD;
            end
         end else if (st_ff.moving_down) begin
            if (v_s <= sp_s + off_s) begin
               st_in.moving_up   = 1'b0;
               st_in.moving_down = 1'b0;
               st_in.status_code = avthc_pkg::ST_GOOD;
            end else if ({1'b0, item.arc_voltage} > rise_lim ||
                         (st_in.down_count > cfg.kerf_wait &&
                          item.arc_voltage >= st_ff.kerf_level)) begin
               st_in.moving_up   = 1'b0;
               st_in.moving_down = 1'b0;
               st_in.status_code = avthc_pkg::ST_KERF;
               st_in.kerf_seen   = 1'b1;
               st_in.regulating  = 1'b0;
            end
         end else if (v_s <= sp_s - on_s) begin
            st_in.moving_up   = 1'b1;
            st_in.moving_down = 1'b0;
            st_in.status_code = avthc_pkg::ST_UP;
         end else if (v_s >= sp_s + on_s && !st_ff.kerf_seen) begin
            st_in.moving_up   = 1'b0;
            st_in.moving_down = 1'b1;
            st_in.status_code = avthc_pkg::ST_DOWN;
            st_in.kerf_level  = item.arc_voltage;
            st_in.down_count  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{default: '0, status_code: avthc_pkg::ST_GOOD};
      end else if (step) begin
         st_ff <= st_in;
      end
   end

   assign result.drive_up       = st_in.moving_up;
   assign result.drive_down     = st_in.moving_down;
   assign result.torch_status   = st_in.status_code;
   assign result.control_active = st_in.regulating;
   assign result.kerf_active    = st_in.kerf_seen;
   assign result.cutting        = st_in.in_cut;
   assign result.pierces        = st_in.pierce_total;

`ifndef NO_ASSERTIONS
   a_drives_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.moving_up && st_ff.moving_down))
      else $error("both drives active");

   a_reg_kerf_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.regulating && st_ff.kerf_seen))
      else $error("control and kerf both active");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !st_ff.in_cut |-> !st_ff.moving_up && !st_ff.moving_down && !st_ff.regulating
                        && !st_ff.kerf_seen)
      else $error("activity outside cut");

   a_pierce_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> st_ff.pierce_total >= $past(st_ff.pierce_total))
      else $error("pierce count went down");
`endif

endmodule

>>> hw/rtl/arc_voltage_torch_height_control.sv
// Arc-voltage torch height control.
// req_chan carries one control pass per transfer: torch_on, arc_good and
// arc_voltage. rsp_chan returns exactly one result per pass: the up/down
// drive outputs, the torch status, the control/kerf/cutting flags and the
// saturating pierce count.
// The csr_ port writes set_point, on_margin, off_margin, stabilize_limit and
// kerf_wait (indexes 0 to 4) at any edge with csr_we high; write only while
// no pass is in flight.
// A pass is registered in the input register, then its result in the result
// register that drives rsp_chan (two register stages).
// Throughput: one pass per cycle while rsp_chan does not stall; the control
// update is a single combinational step between the input and result registers.
// Reset (synchronous, active high) restores the register defaults and
// clears all control state, the pierce count and both pipeline stages.
// When rsp_chan stalls, the held result blocks the input register; if that register
// is empty it still takes one more pass before req_chan.ready drops.
module arc_voltage_torch_height_control (
   input  logic                               clock,
   input  logic                               reset,
   avthc_req_if.sink                          req_chan,
   avthc_rsp_if.source                        rsp_chan,
   input  logic                               csr_we,
   input  logic [avthc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [avthc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   avthc_pkg::cfg_type cfg_ff;
   logic               in_valid_ff;
   avthc_pkg::req_type in_data_ff;
   logic               out_valid_ff;
   avthc_pkg::rsp_type out_data_ff;
   avthc_pkg::rsp_type core_result;
   logic               advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_point       <= avthc_pkg::SET_POINT_RST;
         cfg_ff.on_margin       <= avthc_pkg::ON_MARGIN_RST;
         cfg_ff.off_margin      <= avthc_pkg::OFF_MARGIN_RST;
         cfg_ff.stabilize_limit <= avthc_pkg::STABILIZE_LIMIT_RST;
         cfg_ff.kerf_wait       <= avthc_pkg::KERF_WAIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            avthc_pkg::REG_SET_POINT: begin
               cfg_ff.set_point <= csr_wdata[avthc_pkg::VOLT_W-1:0];
            end
            avthc_pkg::REG_ON_MARGIN: begin
               cfg_ff.on_margin <= csr_wdata[avthc_pkg::MARGIN_W-1:0];
            end
            avthc_pkg::REG_OFF_MARGIN: begin
               cfg_ff.off_margin <= csr_wdata[avthc_pkg::MARGIN_W-1:0];
            end
            avthc_pkg::REG_STABILIZE_LIMIT: begin
               cfg_ff.stabilize_limit <= csr_wdata[avthc_pkg::STAB_W-1:0];
            end
            avthc_pkg::REG_KERF_WAIT: begin
               cfg_ff.kerf_wait <= csr_wdata[avthc_pkg::WAIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff.torch_on    <= req_chan.torch_on;
         in_data_ff.arc_good    <= req_chan.arc_good;
         in_data_ff.arc_voltage <= req_chan.arc_voltage;
      end
   end

   avthc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.drive_up       = out_data_ff.drive_up;
   assign rsp_chan.drive_down     = out_data_ff.drive_down;
   assign rsp_chan.torch_status   = out_data_ff.torch_status;
   assign rsp_chan.control_active = out_data_ff.control_active;
   assign rsp_chan.kerf_active    = out_data_ff.kerf_active;
   assign rsp_chan.cutting        = out_data_ff.cutting;
   assign rsp_chan.pierces        = out_data_ff.pierces;

endmodule

>>> test/arc_voltage_torch_height_control_tb.sv
`timescale 1ns / 1ps

module arc_voltage_torch_height_control_tb;

   localparam int PHASES           = 8;
   localparam int PASSES_PER_PHASE = 128;

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [avthc_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [avthc_pkg::CSR_DATA_W-1:0]  csr_wdata;

   avthc_req_if req_chan ();
   avthc_rsp_if rsp_chan ();

   arc_voltage_torch_height_control DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies
   logic [avthc_pkg::VOLT_W-1:0]   set_point_cfg    = avthc_pkg::SET_POINT_RST;
   logic [avthc_pkg::MARGIN_W-1:0] on_margin_cfg    = avthc_pkg::ON_MARGIN_RST;
   logic [avthc_pkg::MARGIN_W-1:0] off_margin_cfg   = avthc_pkg::OFF_MARGIN_RST;
   logic [avthc_pkg::STAB_W-1:0]   settle_limit_cfg = avthc_pkg::STABILIZE_LIMIT_RST;
   logic [avthc_pkg::WAIT_W-1:0]   kerf_wait_cfg    = avthc_pkg::KERF_WAIT_RST;

   // height control state
   logic                           cut_on        = 1'b0;
   logic                           last_arc      = 1'b0;
   logic                           going_up      = 1'b0;
   logic                           going_down    = 1'b0;
   avthc_pkg::status_type          status_now    = avthc_pkg::ST_GOOD;
   logic                           control_on    = 1'b0;
   logic                           kerf_on       = 1'b0;
   logic [avthc_pkg::VOLT_W-1:0]   kerf_volts    = '0;
   logic [avthc_pkg::WAIT_W-1:0]   down_passes   = '0;
   logic [avthc_pkg::STAB_W-1:0]   settle_passes = '0;
   logic [avthc_pkg::PIERCE_W-1:0] pierce_count  = '0;

   avthc_pkg::req_type pass_queue[$];
   avthc_pkg::rsp_type predicted_status[$];
   avthc_pkg::req_type next_pass;
   avthc_pkg::req_type seen_pass;
   avthc_pkg::rsp_type forecast;
   logic               req_fire = 1'b0;

   int send_gap_pct  = 37;
   int recv_gap_pct  = 51;
   int error_count   = 0;
   int checked_count = 0;
   int queued_total  = 0;
   int settings_used = 1;
   int up_starts     = 0;
   int down_starts   = 0;
   int kerf_events   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic set_drive(input logic up, input logic down,
                            input avthc_pkg::status_type code);
      going_up   = up;
      going_down = down;
      status_now = code;
      if (code == avthc_pkg::ST_UP) up_starts++;
      if (code == avthc_pkg::ST_DOWN) down_starts++;
      if (code == avthc_pkg::ST_KERF) kerf_events++;
   endtask

   task automatic height_control_pass(input avthc_pkg::req_type p,
                                      output avthc_pkg::rsp_type r);
      int v;
      int sp;
      v  = int'(p.arc_voltage);
      sp = int'(set_point_cfg);
      if (p.arc_good && !last_arc && pierce_count != '1) pierce_count++;
      last_arc = p.arc_good;
      if (!p.torch_on) begin
         cut_on     = 1'b0;
         going_up   = 1'b0;
         going_down = 1'b0;
         status_now = avthc_pkg::ST_GOOD;
         control_on = 1'b0;
         kerf_on    = 1'b0;
      end else begin
         if (!cut_on) begin
            cut_on        = 1'b1;
            settle_passes = '0;
         end else begin
            if (settle_passes != '1) settle_passes++;
            if (down_passes != '1) down_passes++;
         end
         if (!p.arc_good) begin
            control_on = 1'b0;
            kerf_on    = 1'b0;
         end else if (!control_on) begin
            if (kerf_on) begin
               if (int'(kerf_volts) >= v) begin
                  kerf_on    = 1'b0;
                  control_on = 1'b1;
               end
            end else if (settle_passes > settle_limit_cfg) begin
               control_on = 1'b1;
            end
         end else if (going_up) begin
            if (v >= sp - int'(off_margin_cfg)) set_drive(1'b0, 1'b0, avthc_pkg::ST_GOOD);
         end else if (going_down) begin
            if (v <= sp + int'(off_margin_cfg)) begin
               set_drive(1'b0, 1'b0, avthc_pkg::ST_GOOD);
            end else if (v > int'(kerf_volts) + int'(avthc_pkg::KERF_RISE) ||
                         (down_passes > kerf_wait_cfg && v >= int'(kerf_volts))) begin
               set_drive(1'b0, 1'b0, avthc_pkg::ST_KERF);
               kerf_on    = 1'b1;
               control_on = 1'b0;
            end
         end else if (v <= sp - int'(on_margin_cfg)) begin
            set_drive(1'b1, 1'b0, avthc_pkg::ST_UP);
         end else if (v >= sp + int'(on_margin_cfg) && !kerf_on) begin
            set_drive(1'b0, 1'b1, avthc_pkg::ST_DOWN);
            kerf_volts  = p.arc_voltage;
            down_passes = '0;
         end
      end
      r.drive_up       = going_up;
      r.drive_down     = going_down;
      r.torch_status   = status_now;
      r.control_active = control_on;
      r.kerf_active    = kerf_on;
      r.cutting        = cut_on;
      r.pierces        = pierce_count;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input avthc_pkg::rsp_type want);
      check_field("drive_up", 32'(want.drive_up), 32'(rsp_chan.drive_up));
      check_field("drive_down", 32'(want.drive_down), 32'(rsp_chan.drive_down));
      check_field("torch_status", 32'(want.torch_status), 32'(rsp_chan.torch_status));
      check_field("control_active", 32'(want.control_active), 32'(rsp_chan.control_active));
      check_field("kerf_active", 32'(want.kerf_active), 32'(rsp_chan.kerf_active));
      check_field("cutting", 32'(want.cutting), 32'(rsp_chan.cutting));
      check_field("pierces", want.pierces, rsp_chan.pierces);
   endtask

   // driver: hold the current pass until its transfer, then advance; drive rsp_chan.ready at random
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         if (pass_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            next_pass = pass_queue.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.torch_on    <= next_pass.torch_on;
            req_chan.arc_good    <= next_pass.arc_good;
            req_chan.arc_voltage <= next_pass.arc_voltage;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_gap_pct);
   end

   // monitor
   always @(posedge clock) begin
      req_fire <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         seen_pass = {req_chan.torch_on, req_chan.arc_good, req_chan.arc_voltage};
         height_control_pass(seen_pass, forecast);
         predicted_status.push_back(forecast);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_status.size() == 0) begin
            $error("result transfer with no pass outstanding");
            error_count++;
         end else begin
            check_result(predicted_status.pop_front());
            checked_count++;
         end
      end
   end

   task automatic add_pass(input logic ton, input logic arc,
                           input logic [avthc_pkg::VOLT_W-1:0] volts);
      avthc_pkg::req_type p;
      p.torch_on    = ton;
      p.arc_good    = arc;
      p.arc_voltage = volts;
      pass_queue.push_back(p);
      queued_total++;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pass_queue.size() != 0 || req_chan.valid || predicted_status.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [avthc_pkg::CSR_IDX_W-1:0] idx,
                            input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[avthc_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         avthc_pkg::REG_SET_POINT:       set_point_cfg    = value[avthc_pkg::VOLT_W-1:0];
         avthc_pkg::REG_ON_MARGIN:       on_margin_cfg    = value[avthc_pkg::MARGIN_W-1:0];
         avthc_pkg::REG_OFF_MARGIN:      off_margin_cfg   = value[avthc_pkg::MARGIN_W-1:0];
         avthc_pkg::REG_STABILIZE_LIMIT: settle_limit_cfg = value[avthc_pkg::STAB_W-1:0];
         avthc_pkg::REG_KERF_WAIT:       kerf_wait_cfg    = value[avthc_pkg::WAIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input int unsigned sp, input int unsigned on,
                                 input int unsigned off, input int unsigned limit,
                                 input int unsigned kw);
      write_reg(avthc_pkg::REG_SET_POINT, sp);
      write_reg(avthc_pkg::REG_ON_MARGIN, on);
      write_reg(avthc_pkg::REG_OFF_MARGIN, off);
      write_reg(avthc_pkg::REG_STABILIZE_LIMIT, limit);
      write_reg(avthc_pkg::REG_KERF_WAIT, kw);
      settings_used++;
   endtask

   task automatic write_random_settings(input int unsigned limit);
      int unsigned on;
      on = $urandom_range(24);
      write_settings($urandom_range(1023), on, $urandom_range(on + 2), limit,
                     $urandom_range(12));
   endtask

   // torch off briefly, then a cut with the voltage wandering about the set point
   task automatic queue_cut_sequence();
      int v;
      repeat ($urandom_range(3, 1)) begin
         add_pass(1'b0, 1'($urandom_range(1)), avthc_pkg::VOLT_W'($urandom_range(1023)));
      end
      v = int'(set_point_cfg) + int'($urandom_range(60)) - 30;
      repeat ($urandom_range(40, 8)) begin
         if ($urandom_range(99) < 12) v = int'($urandom_range(1023));
         else v = v + int'($urandom_range(8)) - 4;
         if (v < 0) v = 0;
         if (v > 1023) v = 1023;
         add_pass($urandom_range(99) >= 3, $urandom_range(99) >= 7,
                  v[avthc_pkg::VOLT_W-1:0]);
      end
   endtask

   initial begin
      int phase_start;
      req_chan.valid       = 1'b0;
      req_chan.torch_on    = 1'b0;
      req_chan.arc_good    = 1'b0;
      req_chan.arc_voltage = '0;
      rsp_chan.ready       = 1'b0;
      csr_we               = 1'b0;
      csr_index            = avthc_pkg::REG_SET_POINT;
      csr_wdata            = '0;
      reset                = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: pierces counted outside a cut, arc lost in a cut
      add_pass(1'b0, 1'b0, 10'd0);
      add_pass(1'b0, 1'b1, 10'd1023);
      add_pass(1'b0, 1'b0, 10'd512);
      add_pass(1'b1, 1'b0, 10'd0);
      add_pass(1'b1, 1'b1, 10'd1023);
      add_pass(1'b0, 1'b1, 10'd0);
      wait_idle();

      write_settings(512, 4, 1, 1, 2);
      add_pass(1'b1, 1'b1, 10'd512);
      add_pass(1'b1, 1'b1, 10'd512);
      add_pass(1'b1, 1'b1, 10'd512);
      add_pass(1'b1, 1'b1, 10'd508);
      add_pass(1'b1, 1'b1, 10'd510);
      add_pass(1'b1, 1'b1, 10'd511);
      add_pass(1'b1, 1'b1, 10'd516);
      add_pass(1'b1, 1'b1, 10'd518);
      add_pass(1'b1, 1'b1, 10'd517);
      add_pass(1'b1, 1'b1, 10'd516);
      add_pass(1'b1, 1'b1, 10'd520);
      add_pass(1'b1, 1'b1, 10'd520);
      add_pass(1'b1, 1'b1, 10'd519);
      add_pass(1'b1, 1'b1, 10'd520);
      add_pass(1'b1, 1'b0, 10'd300);
      add_pass(1'b1, 1'b1, 10'd300);
      add_pass(1'b1, 1'b1, 10'd300);
      add_pass(1'b1, 1'b0, 10'd300);
      add_pass(1'b1, 1'b1, 10'd512);
      add_pass(1'b1, 1'b1, 10'd512);
      add_pass(1'b0, 1'b0, 10'd512);
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 3) begin
            send_gap_pct = 51;
            recv_gap_pct = 37;
         end
         if (ph == 6) begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         case (ph)
            0: write_settings(0, 0, 0, 0, 0);
            1: write_settings(1023, 255, 255, 3, 255);
            5: write_random_settings(16'hFFFF);
            default: write_random_settings($urandom_range(12));
         endcase
         phase_start = queued_total;
         while (queued_total - phase_start < PASSES_PER_PHASE) begin
            queue_cut_sequence();
            if ($urandom_range(7) == 0) wait_idle();
         end
         wait_idle();
      end

      $display("Checked %0d control passes under %0d register settings;", checked_count,
               settings_used);
      $display("predicted %0d torch-up, %0d torch-down and %0d kerf events.", up_starts,
               down_starts, kerf_events);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
